@@ rtl/core/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; imported by the interfaces and all core modules.
package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned PointW = 21;
  localparam int unsigned CountW = 2;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [PointW-1:0] Min2Byte    = 21'h00080;
  localparam logic [PointW-1:0] Max2Byte    = 21'h007FF;
  localparam logic [PointW-1:0] Min3Byte    = 21'h00800;
  localparam logic [PointW-1:0] Max3Byte    = 21'h0FFFD;
  localparam logic [PointW-1:0] Min4Byte    = 21'h10000;
  localparam logic [PointW-1:0] Max4Byte    = 21'h10FFFF;
  localparam logic [UnitW-1:0]  HighSurBase = 16'hD800;
  localparam logic [UnitW-1:0]  LowSurBase  = 16'hDC00;

  localparam logic [CountW-1:0] SeqLen2 = 2'd1;
  localparam logic [CountW-1:0] SeqLen3 = 2'd2;
  localparam logic [CountW-1:0] SeqLen4 = 2'd3;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             bad_sequence;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] n_results;
    result_t    res0;
    result_t    res1;
  } decode_t;

  localparam result_t ErrorResult = '{code_unit: '0, bad_sequence: 1'b1, last_of_run: 1'b1};

  function automatic logic listed_surrogate(input logic [PointW-1:0] v);
    return v == 21'h0D800 || v == 21'h0DB7F || v == 21'h0DB80 || v == 21'h0DBFF ||
           v == 21'h0DC00 || v == 21'h0DF80 || v == 21'h0DFFF;
  endfunction

endpackage

@@ rtl/core/u8u16_if.sv @@
// Valid/ready channel interfaces for UTF-8 bytes in and UTF-16 units out.
// Depends on u8u16_pkg.
interface u8u16_byte_if import u8u16_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;
  logic             end_of_string;

  modport source (output valid, byte_in, end_of_string, input ready);
  modport sink   (input valid, byte_in, end_of_string, output ready);
endinterface

interface u8u16_unit_if import u8u16_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [UnitW-1:0] code_unit;
  logic             bad_sequence;
  logic             last_of_run;

  modport source (output valid, code_unit, bad_sequence, last_of_run, input ready);
  modport sink   (input valid, code_unit, bad_sequence, last_of_run, output ready);
endinterface

@@ rtl/core/u8u16_decode.sv @@
// Sequence state and per-byte decode into up to two UTF-16 results.
// Depends on u8u16_pkg.
module u8u16_decode import u8u16_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             eos_i,
  output decode_t          dec_o
);

  logic [CountW-1:0] pend_q, pend_d;
  logic [CountW-1:0] len_q, len_d;
  logic [PointW-1:0] part_q, part_d;

  logic [PointW-1:0] point;
  logic [PointW-1:0] offs;
  logic [CountW-1:0] pend_dec;

  assign point    = {part_q[PointW-7:0], byte_i[5:0]};
  assign offs     = point - Min4Byte;
  assign pend_dec = pend_q - CountW'(1);

  always_comb begin
    pend_d          = pend_q;
    len_d           = len_q;
    part_d          = part_q;
    dec_o.n_results = 2'd0;
    dec_o.res0      = '0;
    dec_o.res1      = '0;
    if (pend_q == '0) begin
      priority if (byte_i < 8'h80) begin
        dec_o.n_results = 2'd1;
        dec_o.res0      = '{code_unit: UnitW'(byte_i), bad_sequence: 1'b0, last_of_run: 1'b1};
      end else if (byte_i < 8'hC0 || byte_i >= 8'hF8) begin
        dec_o.n_results = 2'd1;
        dec_o.res0      = ErrorResult;
      end else begin
        priority if (byte_i < 8'hE0) begin
          part_d = PointW'(byte_i[4:0]);
          len_d  = SeqLen2;
        end else if (byte_i < 8'hF0) begin
          part_d = PointW'(byte_i[3:0]);
          len_d  = SeqLen3;
        end else begin
          part_d = PointW'(byte_i[2:0]);
          len_d  = SeqLen4;
        end
        pend_d = len_d;
        if (eos_i) begin
          pend_d          = '0;
          len_d           = '0;
          part_d          = '0;
          dec_o.n_results = 2'd1;
          dec_o.res0      = ErrorResult;
        end
      end
    end else if (byte_i[7:6] != 2'b10) begin
      pend_d          = '0;
      len_d           = '0;
      part_d          = '0;
      dec_o.n_results = 2'd1;
      dec_o.res0      = ErrorResult;
    end else if (pend_dec != '0) begin
      pend_d = pend_dec;
      part_d = point;
      if (eos_i) begin
        pend_d          = '0;
        len_d           = '0;
        part_d          = '0;
        dec_o.n_results = 2'd1;
        dec_o.res0      = ErrorResult;
      end
    end else begin
      pend_d          = '0;
      len_d           = '0;
      part_d          = '0;
      dec_o.n_results = 2'd1;
      dec_o.res0      = ErrorResult;
      unique case (len_q)
        SeqLen2: begin
          if (point >= Min2Byte && point <= Max2Byte) begin
            dec_o.res0 = '{code_unit: UnitW'(point), bad_sequence: 1'b0, last_of_run: 1'b1};
          end
        end
        SeqLen3: begin
          if (!listed_surrogate(point) && point >= Min3Byte && point <= Max3Byte) begin
            dec_o.res0 = '{code_unit: UnitW'(point), bad_sequence: 1'b0, last_of_run: 1'b1};
          end
        end
        default: begin
          if (point >= Min4Byte && point <= Max4Byte) begin
            dec_o.n_results = 2'd2;
            dec_o.res0 = '{code_unit: HighSurBase + UnitW'(offs[19:10]),
                           bad_sequence: 1'b0, last_of_run: 1'b0};
            dec_o.res1 = '{code_unit: LowSurBase | UnitW'(offs[9:0]),
                           bad_sequence: 1'b0, last_of_run: 1'b1};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      len_q  <= '0;
      part_q <= '0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      len_q  <= len_d;
      part_q <= part_d;
    end
  end

  a_pend_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != '0 |-> (len_q != '0 && pend_q <= len_q))
    else $error("pending count exceeds sequence length");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == '0 |-> (len_q == '0 && part_q == '0))
    else $error("idle decoder holds stale sequence state");

endmodule

@@ rtl/core/u8u16_outq.sv @@
// Four-entry queue; takes up to two results per push, emits one per cycle while popped.
// Depends on u8u16_pkg.
module u8u16_outq import u8u16_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  decode_t dec_i,
  input  logic    pop_i,
  output logic    room_o,
  output logic    valid_o,
  output result_t head_o
);

  result_t          entries_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic [1:0]       n_push;
  logic             do_pop;
  logic [QPtrW-1:0] wr_ptr_nx;

  assign n_push    = push_i ? dec_i.n_results : 2'd0;
  assign do_pop    = pop_i && valid_o;
  assign valid_o   = cnt_q != '0;
  assign room_o    = cnt_q <= QCntW'(QDepth - 2);
  assign head_o    = entries_q[rd_ptr_q];
  assign wr_ptr_nx = wr_ptr_q + QPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      entries_q[wr_ptr_q] <= dec_i.res0;
    end
    if (n_push == 2'd2) begin
      entries_q[wr_ptr_nx] <= dec_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(n_push) - QCntW'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPtrW'(wr_ptr_q - rd_ptr_q) == QPtrW'(cnt_q))
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/core/utf8_to_utf16_decoder.sv @@
// With the queue empty, a result appears on the output in the cycle after its byte's
// transaction; results already queued ahead of it are emitted first.
// Throughput: one byte per cycle until fewer than two of the four queue entries are free,
// when input stalls; the output drains one result per cycle while out_if.ready is high.
// Reset (rst_ni low, asynchronous): decoder idle, no sequence open, queue empty.
// Top level of the UTF-8 to UTF-16 decoder; depends on u8u16_pkg, u8u16_if,
// u8u16_decode and u8u16_outq.
module utf8_to_utf16_decoder import u8u16_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  u8u16_byte_if.sink   in_if,
  u8u16_unit_if.source out_if
);

  decode_t dec;
  result_t head;
  logic    room;
  logic    accept;

  assign in_if.ready = room;
  assign accept      = in_if.valid && room;

  u8u16_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_if.byte_in),
    .eos_i    (in_if.end_of_string),
    .dec_o    (dec)
  );

  u8u16_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .dec_i   (dec),
    .pop_i   (out_if.ready),
    .room_o  (room),
    .valid_o (out_if.valid),
    .head_o  (head)
  );

  assign out_if.code_unit    = head.code_unit;
  assign out_if.bad_sequence = head.bad_sequence;
  assign out_if.last_of_run  = head.last_of_run;

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.bad_sequence) |-> (out_if.code_unit == '0 && out_if.last_of_run))
    else $error("flagged result not zero or not last");

  a_ascii_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !out_if.valid && dec.n_results != 2'd0) |=> out_if.valid)
    else $error("result missing one cycle after transaction");

endmodule

@@ bench/u8u16_checker.sv @@
// Transaction checker for the UTF-8 to UTF-16 decoder: predicts code units per byte.
// Compares every output transaction with the oldest expected unit.
// Depends on u8u16_pkg and u8u16_if.
module u8u16_checker import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8u16_byte_if       byte_ch,
  u8u16_unit_if       unit_ch,
  output int unsigned mismatches_o,
  output int unsigned units_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CountW-1:0] conts_left;
  logic [PointW-1:0] point_acc;
  logic [CountW-1:0] seq_len;
  result_t           units_due[$];
  result_t           want;

  function automatic void owe(input logic [UnitW-1:0] unit, input logic bad,
                              input logic last);
    result_t r;
    r.code_unit    = unit;
    r.bad_sequence = bad;
    r.last_of_run  = last;
    units_due.insert(units_due.size(), r);
  endfunction

  function automatic void owe_error();
    conts_left = '0;
    point_acc  = '0;
    seq_len    = '0;
    owe('0, 1'b1, 1'b1);
  endfunction

  function automatic void close_point();
    logic [PointW-1:0] v;
    logic [PointW-1:0] w;
    logic [CountW-1:0] len;
    v          = point_acc;
    len        = seq_len;
    conts_left = '0;
    point_acc  = '0;
    seq_len    = '0;
    if (len == SeqLen2) begin
      if (v < 21'h80 || v > 21'h7FF) owe_error();
      else owe(v[15:0], 1'b0, 1'b1);
    end else if (len == SeqLen3) begin
      if (v inside {21'hD800, 21'hDB7F, 21'hDB80, 21'hDBFF, 21'hDC00, 21'hDF80, 21'hDFFF} ||
          v < 21'h800 || v > 21'hFFFD) owe_error();
      else owe(v[15:0], 1'b0, 1'b1);
    end else if (v < 21'h10000 || v > 21'h10FFFF) begin
      owe_error();
    end else begin
      w = v - 21'h10000;
      owe(16'hD800 + {6'd0, w[19:10]}, 1'b0, 1'b0);
      owe(16'hDC00 + {6'd0, w[9:0]}, 1'b0, 1'b1);
    end
  endfunction

  function automatic void take_byte(input logic [ByteW-1:0] b, input logic eos);
    if (conts_left == '0) begin
      if (b < 8'h80) begin
        owe({8'h00, b}, 1'b0, 1'b1);
      end else if (b < 8'hC0 || b >= 8'hF8) begin
        owe_error();
      end else begin
        if (b < 8'hE0) begin
          point_acc = {16'd0, b[4:0]};
          seq_len   = SeqLen2;
        end else if (b < 8'hF0) begin
          point_acc = {17'd0, b[3:0]};
          seq_len   = SeqLen3;
        end else begin
          point_acc = {18'd0, b[2:0]};
          seq_len   = SeqLen4;
        end
        conts_left = seq_len;
        if (eos) owe_error();
      end
    end else if (b[7:6] != 2'b10) begin
      owe_error();
    end else begin
      point_acc  = {point_acc[14:0], b[5:0]};
      conts_left = conts_left - 1'b1;
      if (conts_left == '0) close_point();
      else if (eos) owe_error();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conts_left = '0;
      point_acc  = '0;
      seq_len    = '0;
      units_due.delete();
      mismatches_o = 0;
      units_owed_o = 0;
    end else begin
      if (unit_ch.valid && unit_ch.ready) begin
        if (units_due.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected transaction: expected none, actual unit=%h bad=%b last=%b",
                   $time, unit_ch.code_unit, unit_ch.bad_sequence, unit_ch.last_of_run);
        end else begin
          want = units_due.pop_front();
          if (want.code_unit !== unit_ch.code_unit ||
              want.bad_sequence !== unit_ch.bad_sequence ||
              want.last_of_run !== unit_ch.last_of_run) begin
            mismatches_o++;
            $display("%0t: mismatch: expected unit=%h bad=%b last=%b, actual unit=%h bad=%b last=%b",
                     $time, want.code_unit, want.bad_sequence, want.last_of_run,
                     unit_ch.code_unit, unit_ch.bad_sequence, unit_ch.last_of_run);
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) take_byte(byte_ch.byte_in, byte_ch.end_of_string);
      units_owed_o = units_due.size();
    end
  end

endmodule

@@ bench/tb_utf8_to_utf16_decoder.sv @@
// Top-level testbench for utf8_to_utf16_decoder: drives directed and random UTF-8 bytes
// with random gaps and output stalls, and reports the verdict.
// Depends on u8u16_pkg, u8u16_if, u8u16_checker and the decoder RTL.
module tb_utf8_to_utf16_decoder import u8u16_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes = 650;
  localparam int unsigned CycleLimit  = 400000;
  localparam logic [15:0] ListedSur [7] = '{16'hD800, 16'hDB7F, 16'hDB80, 16'hDBFF,
                                            16'hDC00, 16'hDF80, 16'hDFFF};

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        calm   = 1'b0;
  int unsigned mismatches;
  int unsigned units_owed;
  int unsigned cycles     = 0;
  int unsigned bytes_sent = 0;
  int unsigned stall_left = 0;

  u8u16_byte_if byte_ch ();
  u8u16_unit_if unit_ch ();

  utf8_to_utf16_decoder u_top (
    .clk_i,
    .rst_ni,
    .in_if  (byte_ch),
    .out_if (unit_ch)
  );

  u8u16_checker u_checker (
    .clk_i,
    .rst_ni,
    .byte_ch,
    .unit_ch,
    .mismatches_o (mismatches),
    .units_owed_o (units_owed)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  initial begin
    unit_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        unit_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        unit_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.byte_in       <= b;
    byte_ch.end_of_string <= eos;
    do @(posedge clk_i); while (!byte_ch.ready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Encode cp in n bytes (overlong allowed), send the first keep of them.
  task automatic send_utf8(input logic [20:0] cp, input int unsigned n,
                           input int unsigned keep, input logic eos);
    logic [7:0]  seq [4];
    int unsigned i;
    seq[1] = {2'b10, cp[5:0]};
    seq[2] = {2'b10, cp[5:0]};
    seq[3] = {2'b10, cp[5:0]};
    case (n)
      2: seq[0] = {3'b110, cp[10:6]};
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
      end
      4: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
      end
      default: seq[0] = cp[7:0];
    endcase
    for (i = 0; i < keep; i++) send_byte(seq[i], eos && (i == keep - 1));
  endtask

  initial begin
    int unsigned pick;
    int unsigned n;
    int unsigned first;
    logic [20:0] cp;
    logic [7:0]  b;
    byte_ch.valid         = 1'b0;
    byte_ch.byte_in       = '0;
    byte_ch.end_of_string = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_utf8(21'h80, 2, 2, 1'b0);
    send_utf8(21'h7FF, 2, 2, 1'b1);
    send_utf8(21'h7F, 2, 2, 1'b0);
    send_utf8(21'h800, 3, 3, 1'b0);
    send_utf8(21'hFFFD, 3, 3, 1'b0);
    send_utf8(21'hFFFE, 3, 3, 1'b0);
    send_utf8(21'hFFFF, 3, 3, 1'b1);
    send_utf8(21'h7FF, 3, 3, 1'b0);
    send_utf8(21'hD800, 3, 3, 1'b0);
    send_utf8(21'hDFFF, 3, 3, 1'b0);
    send_utf8(21'hD801, 3, 3, 1'b0);
    send_utf8(21'h10000, 4, 4, 1'b0);
    send_utf8(21'h10FFFF, 4, 4, 1'b1);
    send_utf8(21'h110000, 4, 4, 1'b0);
    send_utf8(21'hFFFF, 4, 4, 1'b0);
    send_utf8(21'h1FFFFF, 4, 4, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_utf8(21'hE9, 2, 1, 1'b0);
    send_byte(8'h41, 1'b0);
    send_utf8(21'hE9, 2, 1, 1'b1);
    send_utf8(21'h20AC, 3, 2, 1'b1);
    send_utf8(21'h1F600, 4, 3, 1'b1);

    first = bytes_sent;
    while (bytes_sent - first < RandomBytes) begin
      if ($urandom_range(0, 49) == 0) calm = !calm;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_byte(8'($urandom_range(0, 8'h7F)), $urandom_range(0, 3) == 0);
      end else if (pick < 40) begin
        cp = ($urandom_range(0, 9) < 8) ? 21'($urandom_range(21'h80, 21'h7FF))
                                        : 21'($urandom_range(0, 21'h7F));
        send_utf8(cp, 2, 2, $urandom_range(0, 3) == 0);
      end else if (pick < 58) begin
        case ($urandom_range(0, 9))
          6: cp = 21'($urandom_range(21'hD800, 21'hDFFF));
          7: cp = {5'd0, ListedSur[3'($urandom_range(0, 6))]};
          8: cp = 21'($urandom_range(21'hFFFD, 21'hFFFF));
          9: cp = 21'($urandom_range(0, 21'h7FF));
          default: cp = 21'($urandom_range(21'h800, 21'hFFFF));
        endcase
        send_utf8(cp, 3, 3, $urandom_range(0, 3) == 0);
      end else if (pick < 74) begin
        case ($urandom_range(0, 9))
          8: cp = 21'($urandom_range(0, 21'hFFFF));
          9: cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
          default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        send_utf8(cp, 4, 4, $urandom_range(0, 3) == 0);
      end else if (pick < 84) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        n  = $urandom_range(2, 4);
        cp = 21'($urandom_range(0, 21'h10FFFF));
        if ($urandom_range(0, 1) == 0) begin
          send_utf8(cp, n, $urandom_range(1, n - 1), 1'b1);
        end else begin
          send_utf8(cp, n, $urandom_range(1, n - 1), 1'b0);
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          send_byte(b, $urandom_range(0, 3) == 0);
        end
      end
    end

    byte_ch.valid <= 1'b0;
    do @(negedge clk_i); while (units_owed != 0);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_if.sv
rtl/core/u8u16_decode.sv
rtl/core/u8u16_outq.sv
rtl/core/utf8_to_utf16_decoder.sv
bench/u8u16_checker.sv
bench/tb_utf8_to_utf16_decoder.sv
